FILE: src/rdag_pkg.sv
// Shared types, codes and helpers for the rotate/decimate address generator.
package rdag_pkg;

    // Field widths fixed by the register map and the result item
    localparam int DIM_W  = 13;
    localparam int PAD_W  = 8;
    localparam int STEP_W = 5;
    localparam int MODE_W = 3;
    localparam int BPP_W  = 3;
    localparam int ADDR_W = 26;
    localparam int ERR_W  = 2;
    localparam int IDX_W  = 3;
    localparam int DATA_W = 13;

    // Largest frame dimension; larger register values are clipped to it
    localparam int MAX_DIM = 4096;
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM > 8191) ? 13'h1FFF : 13'(MAX_DIM);

    // Orientation codes
    localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MIRROR = 3'd4;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
    localparam logic [ERR_W-1:0] ERR_MODE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SRC  = 2'd2;
    localparam logic [ERR_W-1:0] ERR_DST  = 2'd3;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SRC_PAD    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_STEP       = 3'd3;
    localparam logic [IDX_W-1:0] CFG_MODE       = 3'd4;
    localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 3'd5;
    localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 3'd6;
    localparam logic [IDX_W-1:0] CFG_BPP        = 3'd7;

    // Configuration as seen by the datapath, dimensions already clipped
    typedef struct packed {
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  xw;
        logic [DIM_W-1:0]  yh;
        logic [PAD_W-1:0]  pad;
        logic [STEP_W-1:0] step;
        logic [MODE_W-1:0] mode;
        logic [BPP_W-1:0]  bpp;
    } cfg_t;

    // Source and destination position of one pixel
    typedef struct packed {
        logic [DIM_W-1:0] xs;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] xd;
        logic [DIM_W-1:0] yd;
    } pos_t;

    // Walker verdict for the item being accepted
    typedef struct packed {
        logic produce;
        logic last;
        pos_t pos;
    } walk_t;

    // Scaled addresses and limits, signed where they may go negative
    typedef struct packed {
        logic signed [34:0] sa;
        logic signed [32:0] da;
        logic [29:0]        lim_s;
        logic [27:0]        lim_d;
    } calc_t;

    // Clip a dimension register to the supported maximum
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_CAP) ? DIM_CAP : v;
    endfunction

endpackage

FILE: src/rotate_decimate_address_generator_top.sv
// Rotate/decimate address generator: top level with config, pipeline and result stage.
//
// One frame_start/step item may be accepted every clock while in_ready is high; each
// item that lands on a pixel yields one result, offered through four registered stages:
// the frame walker, the row multiplier, the offset and byte-scale stage, and the range
// check with the result register. Items that land on no pixel produce nothing. After an
// error result, items still in flight are dropped up to the next frame_start. The
// configuration port is ready only while no item is in the stages ahead of the result
// register and none is offered, so a write never overtakes an item.
module rotate_decimate_address_generator_top
    import rdag_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] src_addr,
    output logic [ADDR_W-1:0] dst_addr,
    output logic              last_pixel,
    output logic [ERR_W-1:0]  error_code,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0] cfg_data
);

    logic [DIM_W-1:0]  src_width_reg, src_height_reg, dst_width_reg, dst_height_reg;
    logic [PAD_W-1:0]  src_row_pad_reg;
    logic [STEP_W-1:0] step_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [BPP_W-1:0]  bpp_reg;
    cfg_t              cfg;

    walk_t             walk;
    calc_t             calc;
    pos_t              s1_pos_reg;
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic              s1_last_reg, s2_last_reg, s3_last_reg;
    logic              s1_fs_reg, s2_fs_reg, s3_fs_reg;
    logic              squash_reg;
    logic              rdy1, rdy2, rdy3, rdy4, keep;
    logic              src_oor, dst_oor;
    logic [ERR_W-1:0]  err_next;
    logic [ADDR_W-1:0] src_addr_reg, dst_addr_reg;
    logic              last_reg;
    logic [ERR_W-1:0]  err_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= DIM_W'(1);
            src_height_reg  <= DIM_W'(1);
            src_row_pad_reg <= '0;
            step_reg        <= STEP_W'(1);
            mode_reg        <= MODE_NONE;
            dst_width_reg   <= DIM_W'(1);
            dst_height_reg  <= DIM_W'(1);
            bpp_reg         <= BPP_W'(4);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg   <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg  <= cfg_data;
                CFG_SRC_PAD:    src_row_pad_reg <= cfg_data[PAD_W-1:0];
                CFG_STEP:       step_reg        <= cfg_data[STEP_W-1:0];
                CFG_MODE:       mode_reg        <= cfg_data[MODE_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg   <= cfg_data;
                CFG_DST_HEIGHT: dst_height_reg  <= cfg_data;
                CFG_BPP:        bpp_reg         <= cfg_data[BPP_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clip dimensions and bundle the configuration
    always_comb
    begin
        cfg.w    = sat_dim(src_width_reg);
        cfg.h    = sat_dim(src_height_reg);
        cfg.xw   = sat_dim(dst_width_reg);
        cfg.yh   = sat_dim(dst_height_reg);
        cfg.pad  = src_row_pad_reg;
        cfg.step = step_reg;
        cfg.mode = mode_reg;
        cfg.bpp  = bpp_reg;
    end

    // Stage handshake: each stage loads when empty or when it drains
    assign rdy4      = !out_valid_reg || out_ready;
    assign rdy3      = !s3_valid_reg || rdy4;
    assign rdy2      = !s2_valid_reg || rdy3;
    assign rdy1      = !s1_valid_reg || rdy2;
    assign in_ready  = rdy1;
    assign cfg_ready = !(s1_valid_reg || s2_valid_reg || s3_valid_reg) && !in_valid;
    assign keep      = !squash_reg || s3_fs_reg;

    rdag_walker u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_valid && in_ready),
        .frame_start (frame_start),
        .cfg         (cfg),
        .walk        (walk)
    );

    // Hold the walker position of each pixel item
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            s1_pos_reg  <= walk.pos;
            s1_last_reg <= walk.last;
            s1_fs_reg   <= frame_start;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_last_reg <= s1_last_reg;
            s2_fs_reg   <= s1_fs_reg;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_last_reg <= s2_last_reg;
            s3_fs_reg   <= s2_fs_reg;
        end
    end

    rdag_addr_math u_math (
        .clk      (clk),
        .en_mul   (rdy2 && s1_valid_reg),
        .en_scale (rdy3 && s2_valid_reg),
        .pos      (s1_pos_reg),
        .cfg      (cfg),
        .calc     (calc)
    );

    // Range checks in priority order: mode, source, destination
    always_comb
    begin
        src_oor = calc.sa[34] || (calc.sa[33:0] >= {4'b0000, calc.lim_s})
                  || (calc.sa[33:ADDR_W] != '0);
        dst_oor = calc.da[32] || (calc.da[31:0] >= {4'b0000, calc.lim_d})
                  || (calc.da[31:ADDR_W] != '0);
        if (cfg.mode > MODE_MIRROR)
            err_next = ERR_MODE;
        else if (src_oor)
            err_next = ERR_SRC;
        else if (dst_oor)
            err_next = ERR_DST;
        else
            err_next = ERR_OK;
    end

    // Valid bits and the drop flag that follows an error result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            squash_reg    <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= in_valid && walk.produce;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                out_valid_reg <= s3_valid_reg && keep;
            if (rdy4 && s3_valid_reg && keep)
                squash_reg <= (err_next != ERR_OK);
        end
    end

    // Result register: zero the addresses and end the frame on error
    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_valid_reg && keep)
        begin
            src_addr_reg <= (err_next != ERR_OK) ? '0 : calc.sa[ADDR_W-1:0];
            dst_addr_reg <= (err_next != ERR_OK) ? '0 : calc.da[ADDR_W-1:0];
            last_reg     <= s3_last_reg || (err_next != ERR_OK);
            err_reg      <= err_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign src_addr   = src_addr_reg;
    assign dst_addr   = dst_addr_reg;
    assign last_pixel = last_reg;
    assign error_code = err_reg;

endmodule

FILE: src/rdag_walker.sv
// Frame walker: row and column counters for source and destination.
module rdag_walker
    import rdag_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  frame_start,
    input  cfg_t  cfg,
    output walk_t walk
);

    logic [DIM_W-1:0]  src_col_reg, src_row_reg, dst_col_reg, dst_row_reg;
    logic [DIM_W-1:0]  src_col_next, src_row_next, dst_col_next, dst_row_next;
    logic              frame_done_reg, frame_done_next;
    logic [DIM_W-1:0]  cur_col, cur_row, cur_dcol, cur_drow;
    logic              cur_done;
    logic [STEP_W-1:0] step;
    logic [DIM_W:0]    nx, ny;

    // Restart at the first pixel on frame start, then advance by the step
    always_comb
    begin
        cur_col  = frame_start ? '0 : src_col_reg;
        cur_row  = frame_start ? '0 : src_row_reg;
        cur_dcol = frame_start ? '0 : dst_col_reg;
        cur_drow = frame_start ? '0 : dst_row_reg;
        cur_done = frame_start ? ((cfg.w == '0) || (cfg.h == '0)) : frame_done_reg;
        step     = (cfg.step == '0) ? STEP_W'(1) : cfg.step;
        nx       = {1'b0, cur_col} + (DIM_W+1)'(step);
        ny       = {1'b0, cur_row} + (DIM_W+1)'(step);

        src_col_next    = cur_col;
        src_row_next    = cur_row;
        dst_col_next    = cur_dcol;
        dst_row_next    = cur_drow;
        frame_done_next = cur_done;
        walk.last       = 1'b0;

        if (!cur_done)
        begin
            if (nx >= {1'b0, cfg.w})
            begin
                src_col_next = '0;
                dst_col_next = '0;
                dst_row_next = cur_drow + DIM_W'(1);
                if (ny >= {1'b0, cfg.h})
                begin
                    walk.last       = 1'b1;
                    frame_done_next = 1'b1;
                    src_row_next    = '0;
                    dst_row_next    = '0;
                end
                else
                begin
                    src_row_next = ny[DIM_W-1:0];
                end
            end
            else
            begin
                src_col_next = nx[DIM_W-1:0];
                dst_col_next = cur_dcol + DIM_W'(1);
            end
        end

        walk.produce = !cur_done;
        walk.pos.xs  = cur_col;
        walk.pos.y   = cur_row;
        walk.pos.xd  = cur_dcol;
        walk.pos.yd  = cur_drow;
    end

    // Advance the counters on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            dst_col_reg    <= '0;
            dst_row_reg    <= '0;
            frame_done_reg <= 1'b1;
        end
        else if (accept)
        begin
            src_col_reg    <= src_col_next;
            src_row_reg    <= src_row_next;
            dst_col_reg    <= dst_col_next;
            dst_row_reg    <= dst_row_next;
            frame_done_reg <= frame_done_next;
        end
    end

endmodule

FILE: src/rdag_addr_math.sv
// Address arithmetic: multiply stage, then offset and byte-scale stage.
module rdag_addr_math
    import rdag_pkg::*;
(
    input  logic  clk,
    input  logic  en_mul,
    input  logic  en_scale,
    input  pos_t  pos,
    input  cfg_t  cfg,
    output calc_t calc
);

    logic [DIM_W:0]         pitch;
    logic signed [14:0]     rowf, colf, mb, add_d;
    logic [DIM_W-1:0]       ma;
    logic signed [29:0]     prod_s_reg, prod_d_reg;
    logic signed [14:0]     colf_reg, add_d_reg;
    logic [26:0]            lim_ph_reg;
    logic [25:0]            lim_xy_reg;
    logic signed [30:0]     idx_s, idx_d;

    // Pick the row and column terms for the source, flipped for 180 degrees
    always_comb
    begin
        pitch = {1'b0, cfg.w} + (DIM_W+1)'(cfg.pad);
        if (cfg.mode == MODE_ROT180)
        begin
            rowf = $signed({2'b00, cfg.h}) - $signed({2'b00, pos.y}) - 15'sd1;
            colf = $signed({2'b00, cfg.w}) - $signed({2'b00, pos.xs}) - 15'sd1;
        end
        else
        begin
            rowf = $signed({2'b00, pos.y});
            colf = $signed({2'b00, pos.xs});
        end
    end

    // Pick the destination multiplier operands per orientation
    always_comb
    begin
        case (cfg.mode)
            MODE_ROT90:
            begin
                ma    = cfg.yh;
                mb    = $signed({2'b00, pos.xd});
                add_d = $signed({2'b00, cfg.yh}) - $signed({2'b00, pos.yd}) - 15'sd1;
            end
            MODE_ROT270:
            begin
                ma    = cfg.yh;
                mb    = $signed({2'b00, cfg.xw}) - $signed({2'b00, pos.xd}) - 15'sd1;
                add_d = $signed({2'b00, pos.yd});
            end
            MODE_MIRROR:
            begin
                ma    = cfg.xw;
                mb    = $signed({2'b00, pos.yd});
                add_d = $signed({2'b00, cfg.xw}) - $signed({2'b00, pos.xd}) - 15'sd1;
            end
            default:
            begin
                ma    = cfg.xw;
                mb    = $signed({2'b00, pos.yd});
                add_d = $signed({2'b00, pos.xd});
            end
        endcase
    end

    // Multiply stage: row products and frame size products
    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_s_reg <= 30'($signed({1'b0, pitch})) * 30'(rowf);
            prod_d_reg <= 30'($signed({2'b00, ma})) * 30'(mb);
            colf_reg   <= colf;
            add_d_reg  <= add_d;
            lim_ph_reg <= 27'(pitch) * 27'(cfg.h);
            lim_xy_reg <= 26'(cfg.xw) * 26'(cfg.yh);
        end
    end

    // Add the column offset, then scale to bytes
    always_comb
    begin
        idx_s = 31'(prod_s_reg) + 31'(colf_reg);
        idx_d = 31'(prod_d_reg) + 31'(add_d_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en_scale)
        begin
            calc.sa    <= 35'(idx_s) * 35'($signed({1'b0, cfg.bpp}));
            calc.da    <= 33'(idx_d) * 33'sd3;
            calc.lim_s <= 30'(lim_ph_reg) * 30'(cfg.bpp);
            calc.lim_d <= 28'(lim_xy_reg) * 28'd3;
        end
    end

endmodule

FILE: src/rdag_checker.sv
// Port-level checks for the rotate/decimate address generator, bound to the top level.
module rdag_checker
    import rdag_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] src_addr,
    input logic [ADDR_W-1:0] dst_addr,
    input logic              last_pixel,
    input logic [ERR_W-1:0]  error_code,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // An error item carries zero addresses and closes the frame
    a_err_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_OK)
        |-> (src_addr == '0) && (dst_addr == '0) && last_pixel)
        else $error("error item with nonzero address or without last_pixel");

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(src_addr) && $stable(dst_addr)
            && $stable(last_pixel) && $stable(error_code))
        else $error("result item changed while stalled");

    // A register write never lands together with an item
    a_cfg_apart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(in_valid && in_ready))
        else $error("register write accepted together with an item");

    // The register port stays closed while an item is offered
    a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_valid)
        else $error("register port open while an item is offered");

endmodule

bind rotate_decimate_address_generator_top rdag_checker u_rdag_checker (.*);

FILE: sim/tb_rotate_decimate_address_generator_top.sv
// Testbench for the rotate/decimate address generator: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module tb_rotate_decimate_address_generator_top;
    import rdag_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES_PER_ROUND = 12;
    localparam int ITEMS_PER_PHASE = 48;
    localparam longint RGB_BYTES = 3;
    localparam longint ADDR_SPAN = 64'sd1 << ADDR_W;
    // Orientation codes the block rejects
    localparam logic [MODE_W-1:0] MODE_BAD_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_BAD_LAST = 3'd7;

    // One address pair as it leaves the block
    typedef struct packed {
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic              lastp;
        logic [ERR_W-1:0]  err;
    } addr_pair_t;

    // Frame walker copy plus the queue of address pairs still owed by the block
    class addr_pair_scoreboard;
        logic [DIM_W-1:0]  w_reg, h_reg, xw_reg, yh_reg;
        logic [PAD_W-1:0]  pad_reg;
        logic [STEP_W-1:0] step_reg;
        logic [MODE_W-1:0] mode_reg;
        logic [BPP_W-1:0]  bpp_reg;
        int unsigned       src_col, src_row, dst_col, dst_row;
        bit                waiting;
        addr_pair_t        expected_pairs[$];
        int                errors;

        function new();
            w_reg = 1;
            h_reg = 1;
            pad_reg = 0;
            step_reg = 1;
            mode_reg = MODE_NONE;
            xw_reg = 1;
            yh_reg = 1;
            bpp_reg = 4;
            src_col = 0;
            src_row = 0;
            dst_col = 0;
            dst_row = 0;
            waiting = 1'b1;
            errors = 0;
        endfunction

        function longint clip_dim(logic [DIM_W-1:0] v);
            longint r;
            r = v;
            return (r > MAX_DIM) ? MAX_DIM : r;
        endfunction

        function int pending();
            return expected_pairs.size();
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_SRC_WIDTH:  w_reg = data;
                CFG_SRC_HEIGHT: h_reg = data;
                CFG_SRC_PAD:    pad_reg = data[PAD_W-1:0];
                CFG_STEP:       step_reg = data[STEP_W-1:0];
                CFG_MODE:       mode_reg = data[MODE_W-1:0];
                CFG_DST_WIDTH:  xw_reg = data;
                CFG_DST_HEIGHT: yh_reg = data;
                CFG_BPP:        bpp_reg = data[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        // Walk one accepted item and queue the address pair it yields, if any
        function void predict_addresses(bit fs);
            longint      w, h, xw, yh, pitch, bpp, xs, y, xd, yd, sa, da;
            int unsigned stp, nx, ny;
            logic [ERR_W-1:0] err;
            bit          lastp;
            addr_pair_t  pair;
            w = clip_dim(w_reg);
            h = clip_dim(h_reg);
            xw = clip_dim(xw_reg);
            yh = clip_dim(yh_reg);
            pitch = w;
            pitch += pad_reg;
            bpp = bpp_reg;
            stp = (step_reg == 0) ? 1 : step_reg;
            if (fs)
            begin
                src_col = 0;
                src_row = 0;
                dst_col = 0;
                dst_row = 0;
                waiting = (w == 0 || h == 0);
            end
            if (waiting)
                return;
            xs = src_col;
            y = src_row;
            xd = dst_col;
            yd = dst_row;
            err = ERR_OK;
            lastp = 1'b0;
            da = 0;
            if (mode_reg == MODE_ROT180)
                sa = (pitch * (h - 1 - y) + w - 1 - xs) * bpp;
            else
                sa = (pitch * y + xs) * bpp;
            case (mode_reg)
                MODE_NONE, MODE_ROT180: da = (xw * yd + xd) * RGB_BYTES;
                MODE_ROT90:             da = (yh - 1 - yd + xd * yh) * RGB_BYTES;
                MODE_ROT270:            da = ((xw - 1 - xd) * yh + yd) * RGB_BYTES;
                MODE_MIRROR:            da = (xw * yd + xw - 1 - xd) * RGB_BYTES;
                default:                err = ERR_MODE;
            endcase
            if (err == ERR_OK && (sa < 0 || sa >= pitch * h * bpp || sa >= ADDR_SPAN))
                err = ERR_SRC;
            if (err == ERR_OK && (da < 0 || da >= xw * yh * RGB_BYTES || da >= ADDR_SPAN))
                err = ERR_DST;
            if (err != ERR_OK)
            begin
                // End the frame on any error
                sa = 0;
                da = 0;
                lastp = 1'b1;
                waiting = 1'b1;
            end
            else
            begin
                // Advance column, wrapping to the next decimated row
                nx = src_col + stp;
                if (nx >= w)
                begin
                    ny = src_row + stp;
                    src_col = 0;
                    dst_col = 0;
                    dst_row = (dst_row + 1) & 32'h1FFF;
                    if (ny >= h)
                    begin
                        lastp = 1'b1;
                        waiting = 1'b1;
                        src_row = 0;
                        dst_row = 0;
                    end
                    else
                    begin
                        src_row = ny & 32'h1FFF;
                    end
                end
                else
                begin
                    src_col = nx & 32'h1FFF;
                    dst_col = (dst_col + 1) & 32'h1FFF;
                end
            end
            pair.src = ADDR_W'(sa);
            pair.dst = ADDR_W'(da);
            pair.lastp = lastp;
            pair.err = err;
            expected_pairs.push_back(pair);
        endfunction

        task report(string what, longint got, longint want);
            if (errors < 50)
                $display("ERROR %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        // Compare one accepted address pair with the oldest one owed
        task check_addr_pair(addr_pair_t got);
            addr_pair_t want;
            if (expected_pairs.size() == 0)
            begin
                report("unexpected address pair, src_addr", got.src, 0);
                return;
            end
            want = expected_pairs.pop_front();
            if (got.src != want.src)
                report("src_addr", got.src, want.src);
            if (got.dst != want.dst)
                report("dst_addr", got.dst, want.dst);
            if (got.lastp != want.lastp)
                report("last_pixel", got.lastp, want.lastp);
            if (got.err != want.err)
                report("error_code", got.err, want.err);
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              frame_start = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic              last_pixel;
    logic [ERR_W-1:0]  error_code;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    addr_pair_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;

    rotate_decimate_address_generator_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .frame_start(frame_start),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .src_addr(src_addr),
        .dst_addr(dst_addr),
        .last_pixel(last_pixel),
        .error_code(error_code),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("rotate_decimate_address_generator_top: mismatch");
            $finish;
        end
    end

    // Watch the three handshakes
    always @(posedge clk)
    begin
        addr_pair_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.predict_addresses(frame_start);
            if (out_valid && out_ready)
            begin
                got.src = src_addr;
                got.dst = dst_addr;
                got.lastp = last_pixel;
                got.err = error_code;
                sb.check_addr_pair(got);
            end
        end
    end

    // Drive out_ready: random stalls, or a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item and hold it until accepted; returns at a falling edge
    task automatic send_item(bit fs);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed address pair has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write the whole register set while the block is idle
    task automatic set_cfg(int w, int h, int pad, int step, int mode, int xw, int yh, int bpp);
        drain();
        write_reg(CFG_SRC_WIDTH, w);
        write_reg(CFG_SRC_HEIGHT, h);
        write_reg(CFG_SRC_PAD, pad);
        write_reg(CFG_STEP, step);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_DST_WIDTH, xw);
        write_reg(CFG_DST_HEIGHT, yh);
        write_reg(CFG_BPP, bpp);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic run_directed();
        logic [MODE_W-1:0] modes[5];
        int i;
        modes = '{MODE_NONE, MODE_ROT90, MODE_ROT180, MODE_ROT270, MODE_MIRROR};
        // Reset config: a single-pixel frame, then an item the idle walker drops
        send_item(1'b1);
        send_item(1'b0);
        // Small 2x2 frame in every orientation
        for (i = 0; i < 5; i++)
        begin
            set_cfg(2, 2, 1, 1, modes[i], 2, 2, 3);
            send_item(1'b1);
            send_item(1'b0);
            if (modes[i] == MODE_MIRROR)
            begin
                // Restart in the middle of the frame
                send_item(1'b1);
                send_item(1'b0);
            end
            send_item(1'b0);
            send_item(1'b0);
        end
        // Rejected orientation, then the frame stays closed
        set_cfg(2, 2, 0, 1, MODE_BAD_LAST, 2, 2, 4);
        send_item(1'b1);
        send_item(1'b0);
        // Empty frame
        set_cfg(0, 2, 0, 1, MODE_NONE, 1, 1, 4);
        send_item(1'b1);
        // Clipped dimensions, zero step, source beyond the address span
        set_cfg(8191, 8191, 255, 0, MODE_ROT180, 8191, 8191, 7);
        send_item(1'b1);
        // Destination too small for the frame
        set_cfg(4, 1, 0, 0, MODE_NONE, 1, 1, 4);
        send_item(1'b1);
        send_item(1'b0);
        // Receiver holds off while a whole 4x4 frame keeps coming, so the block fills
        set_cfg(4, 4, 0, 1, MODE_NONE, 4, 4, 4);
        hold_req = 1'b1;
        send_item(1'b1);
        for (i = 0; i < 15; i++)
            send_item(1'b0);
    endtask

    // Pick a register set: mostly consistent small frames, some large or arbitrary
    task automatic random_cfg();
        int kind, w, h, s, se, pad, mode, bpp, xw, yh, wc, hc;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
        end
        else if (kind == 7)
        begin
            w = $urandom_range(1, 8191);
            h = $urandom_range(1, 8191);
            s = $urandom_range(8, 16);
        end
        else
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8191);
            h = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            s = $urandom_range(0, 31);
        end
        pad = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
        mode = ($urandom_range(0, 9) == 0) ? $urandom_range(MODE_BAD_FIRST, MODE_BAD_LAST)
                                           : $urandom_range(MODE_NONE, MODE_MIRROR);
        bpp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(3, 4);
        se = (s == 0) ? 1 : s;
        wc = (w > MAX_DIM) ? MAX_DIM : w;
        hc = (h > MAX_DIM) ? MAX_DIM : h;
        xw = (wc + se - 1) / se;
        yh = (hc + se - 1) / se;
        if (kind == 9 || $urandom_range(0, 19) == 0)
        begin
            xw = $urandom_range(0, 8191);
            yh = $urandom_range(0, 20);
        end
        set_cfg(w, h, pad, s, mode, xw, yh, bpp);
    endtask

    task automatic run_round(int tx_pct, int rx_pct, bit pressure);
        int  phase, counted;
        bit  fs;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (phase = 0; phase < PHASES_PER_ROUND; phase++)
        begin
            random_cfg();
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // Long receiver hold-off while items keep coming
                if (pressure && phase == 1 && counted == 10)
                    hold_req = 1'b1;
                // Pause the sender until the block has emptied
                if (pressure && phase == 2 && counted == 24)
                    drain();
                if (sb.waiting)
                    fs = ($urandom_range(0, 9) != 0);
                else
                    fs = ($urandom_range(0, 49) == 0);
                if (fs || !sb.waiting)
                    counted++;
                send_item(fs);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle_pct = 22;
        rx_idle_pct = 83;
        run_directed();
        run_round(22, 83, 1'b0);
        run_round(83, 22, 1'b0);
        run_round(0, 0, 1'b1);
        // Wait out the tail and any stray results
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("rotate_decimate_address_generator_top: match");
        else
            $display("rotate_decimate_address_generator_top: mismatch");
        $finish;
    end

endmodule

FILE: rotate_decimate_address_generator_top.f
src/rdag_pkg.sv
src/rdag_walker.sv
src/rdag_addr_math.sv
src/rotate_decimate_address_generator_top.sv
src/rdag_checker.sv
sim/tb_rotate_decimate_address_generator_top.sv
